// ===== design/ptm_pkg.sv =====
// Package for the timer/noise sound mixer: command codes, payload structs,
// state machine encoding. No dependencies.
`timescale 1ns / 1ps
package ptm_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_TWRITE = 3'd1,
        CMD_TREAD  = 3'd2,
        CMD_GATE   = 3'd3,
        CMD_VOLUME = 3'd4,
        CMD_NOISE  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] offset;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [7:0]         read_data;
    } out_item_t;

    // Sequencer phases of one tick
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NOISE_A,
        ST_TMR0,
        ST_TMR1,
        ST_NOISE_B,
        ST_PRE3,
        ST_TMR2,
        ST_MIX,
        ST_OUT
    } state_t;

    localparam logic [16:0] NOISE_RESET = 17'h1FFFF;

endpackage

// ===== design/ptm_timer_noise_sound_mixer.sv =====
// Top level of the timer/noise sound mixer: command decode, sequencer, shared
// one-clock-per-cycle timer/noise stepper and mixer. Uses ptm_pkg.
// Non-tick item: result registered at the accepting edge; no new item is taken while a result waits.
// Tick: steps the noise, timer 0, timer 1, noise again per timer 1 rise, timer 2 prescale and
// timer 2 phases, then mixes and registers the result; with cw_reg[0] bit 0 set it goes straight to mix.
// Reset (rst_n asynchronous, active low) clears state; step_reg to 32'h1000_0000, noise register to all ones.
`timescale 1ns / 1ps
module ptm_timer_noise_sound_mixer
    import ptm_pkg::*;
#(
    parameter int NOISE_DIVIDE = 10
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);
    localparam int NDW = $clog2(NOISE_DIVIDE + 1);

    state_t state_reg, state_next;
    logic [31:0] step_reg;
    logic [7:0]  cw_reg [3];
    logic [15:0] cnt_reg [3];
    logic [15:0] rel_reg [3];
    logic [2:0]  lvl_reg;
    logic [2:0]  pre_reg;
    logic [7:0]  msb_reg, lsb_reg;
    logic [7:0]  vol_reg [4];
    logic [23:0] phase_reg;
    logic [16:0] noise_reg;
    logic [NDW-1:0] ndiv_reg;
    logic        gate_reg, nclk1_reg, nclk3_reg;
    logic [8:0]  rem_reg;     // clocks left for current phase
    logic [8:0]  ticks_reg;
    logic [8:0]  rises_reg;
    logic [1:0]  ch_reg;
    logic        noisy_reg;
    logic [2:0]  lv_reg;
    logic [15:0] acc_reg;
    logic [2:0]  mix_idx_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Shared timer stepper: one timer clock for channel ch_reg
    logic [15:0] c, r, cnt_step;
    logic        lvl_step, rise_step;
    always_comb
    begin
        c = cnt_reg[ch_reg];
        r = rel_reg[ch_reg];
        cnt_step = c;
        lvl_step = lvl_reg[ch_reg];
        rise_step = 1'b0;
        if (cw_reg[ch_reg][2]) begin
            if (c[7:0] != 8'd0) begin
                cnt_step = {c[15:8], c[7:0] - 8'd1};
            end else if (c[15:8] == 8'd0) begin
                lvl_step = 1'b0;
                cnt_step = r;
            end else begin
                cnt_step = {c[15:8] - 8'd1, r[7:0]};
                if (c[15:8] == 8'd1) begin
                    lvl_step = 1'b1;
                    rise_step = 1'b1;
                end
            end
        end else begin
            if (c != 16'd0) begin
                cnt_step = c - 16'd1;
            end else begin
                cnt_step = r;
                lvl_step = ~lvl_reg[ch_reg];
                rise_step = ~lvl_reg[ch_reg];
            end
        end
    end

    // Noise one clock
    logic [16:0] noise_step;
    logic [NDW-1:0] ndiv_step;
    always_comb
    begin
        noise_step = noise_reg;
        ndiv_step = ndiv_reg + NDW'(1);
        if (ndiv_step >= NDW'(NOISE_DIVIDE)) begin
            ndiv_step = '0;
            noise_step = {noise_reg[15:0], noise_reg[16] ^ noise_reg[13]};
        end
    end

    logic [32:0] acc_sum;
    assign acc_sum = {9'd0, phase_reg} + {1'b0, step_reg};

    logic [2:0] p3sum_lo;
    logic [8:0] p3n;
    logic [9:0] p3sum;
    assign p3n = cw_reg[2][1] ? ticks_reg : {8'd0, nclk3_reg};
    assign p3sum = {1'b0, p3n} + {7'd0, pre_reg};
    assign p3sum_lo = p3sum[2:0];

    // Read byte returned by a timer or noise read
    logic [7:0] rd_val;
    always_comb
    begin
        rd_val = '0;
        case (in_item.command)
            CMD_TREAD: begin
                if (in_item.offset[2:1] != 2'd0) begin
                    if (!in_item.offset[0])
                        rd_val = cnt_reg[in_item.offset[2:1] - 2'd1][15:8];
                    else
                        rd_val = lsb_reg;
                end
            end
            CMD_NOISE: rd_val = {7'd0, noise_reg[0]};
            default: ;
        endcase
    end

    // Mixer term for channel mix_idx_reg
    logic       mbit;
    logic [7:0] mvol;
    logic [15:0] mterm;
    always_comb
    begin
        case (mix_idx_reg)
            3'd0: begin mbit = gate_reg;   mvol = vol_reg[0]; end
            3'd1: begin mbit = lv_reg[0];  mvol = vol_reg[1]; end
            3'd2: begin mbit = lv_reg[1];  mvol = vol_reg[2]; end
            default: begin mbit = lv_reg[2]; mvol = vol_reg[3]; end
        endcase
        mterm = (mbit ^ mvol[7]) ? -{9'd0, mvol[6:0]} : {9'd0, mvol[6:0]};
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid && in_ready && in_item.command == CMD_TICK)
                            state_next = (cw_reg[0][0]) ? ST_MIX : ST_NOISE_A;
            ST_NOISE_A: if (!noisy_reg || rem_reg == 9'd0) state_next = ST_TMR0;
            ST_TMR0:    if (rem_reg == 9'd0) state_next = ST_TMR1;
            ST_TMR1:    if (rem_reg == 9'd0) state_next = ST_NOISE_B;
            ST_NOISE_B: if (!noisy_reg || rises_reg == 9'd0) state_next = ST_PRE3;
            ST_PRE3:    state_next = ST_TMR2;
            ST_TMR2:    if (rem_reg == 9'd0) state_next = ST_MIX;
            ST_MIX:     if (mix_idx_reg == 3'd4) state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= 32'h1000_0000;
            for (int i = 0; i < 3; i++) begin
                cw_reg[i] <= '0; cnt_reg[i] <= '0; rel_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) vol_reg[i] <= '0;
            lvl_reg <= '0; pre_reg <= '0; msb_reg <= '0; lsb_reg <= '0;
            phase_reg <= '0; noise_reg <= NOISE_RESET; ndiv_reg <= '0;
            gate_reg <= 1'b0; nclk1_reg <= 1'b0; nclk3_reg <= 1'b0;
            rem_reg <= '0; ticks_reg <= '0; rises_reg <= '0; ch_reg <= '0;
            noisy_reg <= 1'b0; lv_reg <= '0; acc_reg <= '0; mix_idx_reg <= '0;
            out_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) step_reg <= cfg_data;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid && in_ready) begin
                        out_reg <= {16'd0, rd_val};
                        out_valid_reg <= (in_item.command != CMD_TICK);
                        case (in_item.command)
                            CMD_TICK: begin
                                phase_reg <= acc_sum[23:0];
                                ticks_reg <= acc_sum[32:24];
                                rem_reg <= acc_sum[32:24];
                                noisy_reg <= ~(cw_reg[0][1] & cw_reg[2][1]);
                                lv_reg <= '0; acc_reg <= '0; mix_idx_reg <= '0;
                                rises_reg <= '0;
                            end
                            CMD_TWRITE: begin
                                if (in_item.offset == 3'd0) begin
                                    if (cw_reg[1][0]) cw_reg[0] <= in_item.data;
                                    else              cw_reg[2] <= in_item.data;
                                end else if (in_item.offset == 3'd1) begin
                                    cw_reg[1] <= in_item.data;
                                end else if (!in_item.offset[0]) begin
                                    msb_reg <= in_item.data;
                                end else begin
                                    rel_reg[in_item.offset[2:1] - 2'd1] <=
                                        {msb_reg, in_item.data};
                                    if (!cw_reg[in_item.offset[2:1] - 2'd1][4])
                                        cnt_reg[in_item.offset[2:1] - 2'd1] <=
                                            {msb_reg, in_item.data};
                                end
                            end
                            CMD_TREAD: begin
                                if (in_item.offset[2:1] != 2'd0 && !in_item.offset[0])
                                    lsb_reg <= cnt_reg[in_item.offset[2:1] - 2'd1][7:0];
                            end
                            CMD_GATE: begin
                                gate_reg <= in_item.data[7];
                                if (!gate_reg && in_item.data[7]) nclk1_reg <= noise_reg[0];
                            end
                            CMD_VOLUME: begin
                                if (!in_item.offset[2]) vol_reg[in_item.offset[1:0]] <= in_item.data;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_NOISE_A: begin
                    if (noisy_reg && rem_reg != 9'd0) begin
                        noise_reg <= noise_step; ndiv_reg <= ndiv_step;
                        rem_reg <= rem_reg - 9'd1;
                    end else begin
                        ch_reg <= 2'd0;
                        rem_reg <= cw_reg[0][1] ? ticks_reg : {8'd0, nclk1_reg};
                    end
                end
                ST_TMR0, ST_TMR1, ST_TMR2: begin
                    if (rem_reg != 9'd0) begin
                        cnt_reg[ch_reg] <= cnt_step;
                        lvl_reg[ch_reg] <= lvl_step;
                        if (rise_step) rises_reg <= rises_reg + 9'd1;
                        rem_reg <= rem_reg - 9'd1;
                    end else begin
                        lv_reg[ch_reg] <= lvl_reg[ch_reg] & cw_reg[ch_reg][7];
                        if (state_reg == ST_TMR0) begin
                            ch_reg <= 2'd1;
                            rem_reg <= cw_reg[1][1] ? ticks_reg : 9'd0;
                            rises_reg <= '0;
                        end
                    end
                end
                ST_NOISE_B: begin
                    if (noisy_reg && rises_reg != 9'd0) begin
                        noise_reg <= noise_step; ndiv_reg <= ndiv_step;
                        rises_reg <= rises_reg - 9'd1;
                    end else if (noisy_reg && cw_reg[1][1] && ticks_reg != 9'd0) begin
                        nclk3_reg <= noise_reg[0];
                    end
                end
                ST_PRE3: begin
                    ch_reg <= 2'd2;
                    if (cw_reg[2][0]) begin
                        pre_reg <= p3sum_lo;
                        rem_reg <= {2'd0, p3sum[9:3]};
                    end else begin
                        rem_reg <= p3n;
                    end
                end
                ST_MIX: begin
                    if (mix_idx_reg != 3'd4) begin
                        acc_reg <= acc_reg + mterm;
                        mix_idx_reg <= mix_idx_reg + 3'd1;
                    end
                end
                ST_OUT: begin
                    out_reg <= {acc_reg[9:0], 6'd0, 8'd0};
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule
